// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the dirty tile tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/dtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile tracker package
// Beat types, command and register codes and sizing constants.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int TILE_PIXELS   = 64;
    localparam int TILE_SHIFT    = $clog2(TILE_PIXELS);
    localparam int MAX_TILE_COLS = 64;
    localparam int MAX_TILE_ROWS = 64;
    localparam int ROW_W         = $clog2(MAX_TILE_ROWS);
    localparam int ROW_CNT_W     = $clog2(MAX_TILE_ROWS + 1);
    localparam int COL_CNT_W     = $clog2(MAX_TILE_COLS + 1);
    localparam int CANVAS_W      = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int MASK_W        = 64;
    localparam int OUT_ROW_W     = 6;

    localparam logic [1:0] CMD_MARK  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_ABORT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
    } t_in_beat;

    typedef struct packed {
        logic                 from_stroke_map;
        logic [OUT_ROW_W-1:0] tile_row;
        logic [MASK_W-1:0]    column_mask;
        logic                 last_row;
    } t_out_beat;

    typedef struct packed {
        logic                 none;
        logic [ROW_W-1:0]     row_first;
        logic [ROW_CNT_W-1:0] row_end;
        logic [MASK_W-1:0]    mask;
    } t_span;

endpackage

// ----- hdl/dtt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/dtt_quant.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile tracker quantizer
// Turns a pixel rectangle into a tile row span and a column mask.
// ----------------------------------------------------------------------------
module dtt_quant
    import dtt_pkg::*;
(
    input  logic [CANVAS_W-1:0] i_canvas_w,
    input  logic [CANVAS_W-1:0] i_canvas_h,
    input  t_in_beat            i_req,
    output t_span               o_span
);

    localparam int CSUM_W  = CANVAS_W + 1;
    localparam int CTILE_W = CSUM_W - TILE_SHIFT;
    localparam int ESUM_W  = 17;
    localparam int END_W   = ESUM_W - TILE_SHIFT;
    localparam int BEG_W   = 15 - TILE_SHIFT;

    logic [CSUM_W-1:0]    w_wsum, w_hsum;
    logic [CTILE_W-1:0]   w_wt, w_ht;
    logic [COL_CNT_W-1:0] w_cols;
    logic [ROW_CNT_W-1:0] w_rows;
    logic [14:0]          w_sx, w_sy;
    logic [BEG_W-1:0]     w_x0, w_y0;
    logic [ESUM_W-1:0]    w_xsum, w_ysum;
    logic [END_W-1:0]     w_x1raw, w_y1raw;
    logic [COL_CNT_W-1:0] w_x1;
    logic [ROW_CNT_W-1:0] w_y1;

    always_comb begin
        w_wsum = {1'b0, i_canvas_w} + CSUM_W'(TILE_PIXELS - 1);
        w_hsum = {1'b0, i_canvas_h} + CSUM_W'(TILE_PIXELS - 1);
        w_wt   = CTILE_W'(w_wsum >> TILE_SHIFT);
        w_ht   = CTILE_W'(w_hsum >> TILE_SHIFT);
        w_cols = (w_wt > CTILE_W'(MAX_TILE_COLS)) ? COL_CNT_W'(MAX_TILE_COLS)
                                                 : COL_CNT_W'(w_wt);
        w_rows = (w_ht > CTILE_W'(MAX_TILE_ROWS)) ? ROW_CNT_W'(MAX_TILE_ROWS)
                                                 : ROW_CNT_W'(w_ht);

        w_sx = i_req.rect_x[15] ? '0 : i_req.rect_x[14:0];
        w_sy = i_req.rect_y[15] ? '0 : i_req.rect_y[14:0];
        w_x0 = BEG_W'(w_sx >> TILE_SHIFT);
        w_y0 = BEG_W'(w_sy >> TILE_SHIFT);

        w_xsum  = ESUM_W'(w_sx) + ESUM_W'(i_req.rect_w) + ESUM_W'(TILE_PIXELS - 1);
        w_ysum  = ESUM_W'(w_sy) + ESUM_W'(i_req.rect_h) + ESUM_W'(TILE_PIXELS - 1);
        w_x1raw = END_W'(w_xsum >> TILE_SHIFT);
        w_y1raw = END_W'(w_ysum >> TILE_SHIFT);
        w_x1 = (w_x1raw > END_W'(w_cols)) ? w_cols : COL_CNT_W'(w_x1raw);
        w_y1 = (w_y1raw > END_W'(w_rows)) ? w_rows : ROW_CNT_W'(w_y1raw);

        o_span.none = (w_x0 >= BEG_W'(w_x1)) || (w_y0 >= BEG_W'(w_y1));
        o_span.row_first = ROW_W'(w_y0);
        o_span.row_end   = w_y1;
        o_span.mask      = '0;
        for (int c = 0; c < MAX_TILE_COLS; c++) begin
            o_span.mask[c] = (BEG_W'(c) >= w_x0) && (BEG_W'(c) < BEG_W'(w_x1));
        end
    end

endmodule

// ----- hdl/dirty_tile_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile tracker
// Recent and stroke tile bitmaps held in two row RAMs, updated by marks and
// reported row by row on tick and flush.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Beat
//  input     in         i_valid / o_ready         t_in_beat command and rectangle
//  output    out        o_valid / i_ready         t_out_beat row report
//  config    in         i_cfg_valid / o_cfg_ready register index and data
//
//  A mark runs a prepare state, then one RAM read and one write per covered
//  tile row. Tick and flush read and report each dirty row, or one empty last
//  beat when nothing is dirty. Per-row valid flops clear both maps at once on
//  reset, abort or a canvas size write. A stalled output holds the scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dirty_tile_tracker_unit
    import dtt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_beat             i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_beat            o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CANVAS_W-1:0]  i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MPREP = 3'd1;
    localparam logic [2:0] S_MRD   = 3'd2;
    localparam logic [2:0] S_MWR   = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SDAT  = 3'd5;
    localparam logic [2:0] S_EMPTY = 3'd6;

    logic [2:0]               r_state, n_state;
    logic [MAX_TILE_ROWS-1:0] r_rvld, n_rvld;
    logic [MAX_TILE_ROWS-1:0] r_svld, n_svld;
    logic [MAX_TILE_ROWS-1:0] r_pend, n_pend;
    logic                     r_out_vld, n_out_vld;
    logic [CANVAS_W-1:0]      r_canvas_w, n_canvas_w;
    logic [CANVAS_W-1:0]      r_canvas_h, n_canvas_h;
    t_out_beat                r_out, n_out;
    t_in_beat                 r_req, n_req;
    logic                     r_sel, n_sel;
    logic [ROW_W-1:0]         r_cur_row, n_cur_row;
    logic [ROW_CNT_W-1:0]     r_row, n_row;
    logic [ROW_CNT_W-1:0]     r_row_end, n_row_end;
    logic [MASK_W-1:0]        r_mask, n_mask;

    t_span                    w_span;
    logic                     w_in_acc;
    logic                     w_cfg_acc;
    logic                     w_out_free;
    logic                     w_ram_re;
    logic                     w_ram_we;
    logic [ROW_W-1:0]         w_raddr;
    logic [ROW_W-1:0]         w_pick;
    logic [MAX_TILE_ROWS-1:0] w_pend_rest;
    logic                     w_last;
    logic [MASK_W-1:0]        w_rrd, w_srd;
    logic [MASK_W-1:0]        w_rmerge, w_smerge;
    logic [ROW_CNT_W-1:0]     w_row_inc;

    function automatic logic [ROW_W-1:0] lowest_row(input logic [MAX_TILE_ROWS-1:0] p);
        logic [MAX_TILE_ROWS-1:0] oh;
        logic [ROW_W-1:0]         idx;
        oh  = p & (~p + MAX_TILE_ROWS'(1));
        idx = '0;
        for (int i = 0; i < MAX_TILE_ROWS; i++) begin
            idx = idx | (oh[i] ? ROW_W'(i) : '0);
        end
        return idx;
    endfunction

    dtt_quant u_quant (
        .i_canvas_w (r_canvas_w),
        .i_canvas_h (r_canvas_h),
        .i_req      (r_req),
        .o_span     (w_span)
    );

    dtt_ram #(
        .WIDTH (MASK_W),
        .DEPTH (MAX_TILE_ROWS)
    ) u_recent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_row[ROW_W-1:0]),
        .i_wdata (w_rmerge),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rrd)
    );

    dtt_ram #(
        .WIDTH (MASK_W),
        .DEPTH (MAX_TILE_ROWS)
    ) u_stroke_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_row[ROW_W-1:0]),
        .i_wdata (w_smerge),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_srd)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_data      = r_out;

    assign w_in_acc    = i_valid && o_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_vld || i_ready;
    assign w_ram_re    = (r_state == S_MRD) || (r_state == S_SRD);
    assign w_ram_we    = (r_state == S_MWR);
    assign w_pick      = lowest_row(r_pend);
    assign w_raddr     = (r_state == S_SRD) ? w_pick : r_row[ROW_W-1:0];
    assign w_pend_rest = r_pend & (r_pend - MAX_TILE_ROWS'(1));
    assign w_last      = (w_pend_rest == '0);
    assign w_rmerge    = (r_rvld[r_row[ROW_W-1:0]] ? w_rrd : '0) | r_mask;
    assign w_smerge    = (r_svld[r_row[ROW_W-1:0]] ? w_srd : '0) | r_mask;
    assign w_row_inc   = r_row + ROW_CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_rvld     = r_rvld;
        n_svld     = r_svld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld;
        n_canvas_w = r_canvas_w;
        n_canvas_h = r_canvas_h;
        n_out      = r_out;
        n_req      = r_req;
        n_sel      = r_sel;
        n_cur_row  = r_cur_row;
        n_row      = r_row;
        n_row_end  = r_row_end;
        n_mask     = r_mask;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_data.command)
                        CMD_MARK: begin
                            n_req   = i_data;
                            n_state = S_MPREP;
                        end
                        CMD_TICK: begin
                            n_sel   = 1'b0;
                            n_pend  = r_rvld;
                            n_rvld  = '0;
                            n_state = (r_rvld == '0) ? S_EMPTY : S_SRD;
                        end
                        CMD_FLUSH: begin
                            n_sel   = 1'b1;
                            n_pend  = r_svld;
                            n_svld  = '0;
                            n_state = (r_svld == '0) ? S_EMPTY : S_SRD;
                        end
                        CMD_ABORT: begin
                            n_rvld = '0;
                            n_svld = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MPREP: begin
                n_row     = ROW_CNT_W'(w_span.row_first);
                n_row_end = w_span.row_end;
                n_mask    = w_span.mask;
                n_state   = w_span.none ? S_IDLE : S_MRD;
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                n_rvld[r_row[ROW_W-1:0]] = 1'b1;
                n_svld[r_row[ROW_W-1:0]] = 1'b1;
                n_row   = w_row_inc;
                n_state = (w_row_inc == r_row_end) ? S_IDLE : S_MRD;
            end
            S_SRD: begin
                n_cur_row = w_pick;
                n_state   = S_SDAT;
            end
            S_SDAT: begin
                if (w_out_free) begin
                    n_out_vld             = 1'b1;
                    n_out.from_stroke_map = r_sel;
                    n_out.tile_row        = OUT_ROW_W'(r_cur_row);
                    n_out.column_mask     = r_sel ? w_srd : w_rrd;
                    n_out.last_row        = w_last;
                    n_pend                = w_pend_rest;
                    n_state               = w_last ? S_IDLE : S_SRD;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_vld             = 1'b1;
                    n_out.from_stroke_map = r_sel;
                    n_out.tile_row        = '0;
                    n_out.column_mask     = '0;
                    n_out.last_row        = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH: begin
                    n_canvas_w = i_cfg_data;
                    n_rvld     = '0;
                    n_svld     = '0;
                end
                CFG_CANVAS_HEIGHT: begin
                    n_canvas_h = i_cfg_data;
                    n_rvld     = '0;
                    n_svld     = '0;
                end
                default: begin
                    n_canvas_w = r_canvas_w;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rvld     <= '0;
            r_svld     <= '0;
            r_pend     <= '0;
            r_out_vld  <= 1'b0;
            r_canvas_w <= CANVAS_RESET;
            r_canvas_h <= CANVAS_RESET;
        end else begin
            r_state    <= n_state;
            r_rvld     <= n_rvld;
            r_svld     <= n_svld;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
            r_canvas_w <= n_canvas_w;
            r_canvas_h <= n_canvas_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_req     <= n_req;
        r_sel     <= n_sel;
        r_cur_row <= n_cur_row;
        r_row     <= n_row;
        r_row_end <= n_row_end;
        r_mask    <= n_mask;
    end

    `ASSERT_IMPLY(a_write_in_span, i_clk, i_rst_n, w_ram_we, (r_row < r_row_end), "RAM write outside the marked row span")
    `ASSERT_NEXT(a_tick_snapshot, i_clk, i_rst_n, w_in_acc && (i_data.command == CMD_TICK), (r_pend == $past(r_rvld)) && (r_rvld == '0), "tick did not snapshot and clear the recent map")
    `ASSERT_IMPLY(a_scan_has_row, i_clk, i_rst_n, (r_state == S_SRD), (r_pend != '0), "row scan started with no pending row")
    `ASSERT_NEXT(a_last_ends_scan, i_clk, i_rst_n, (r_state == S_SDAT) && w_out_free && w_last, (r_state == S_IDLE) && (r_pend == '0) && r_out_vld && r_out.last_row, "last row beat did not end the scan")

endmodule

// ----- tb/dirty_tile_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile tracker checker
// Watches the request, row report and register channels of the tracker, keeps
// its own copy of both tile maps and the canvas size, and compares every row
// beat with the oldest predicted one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module dirty_tile_checker
    import dtt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_beat             i_in_beat,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_beat            i_out_beat,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CANVAS_W-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [CANVAS_W-1:0] canvas_width;
    logic [CANVAS_W-1:0] canvas_height;
    logic [MASK_W-1:0]   recent_map [MAX_TILE_ROWS];
    logic [MASK_W-1:0]   stroke_map [MAX_TILE_ROWS];
    t_out_beat           expected_rows [$];

    function automatic int unsigned tiles_spanned(input logic [CANVAS_W-1:0] pixels,
                                                  input int unsigned limit);
        int unsigned n;
        n = (int'(pixels) + TILE_PIXELS - 1) / TILE_PIXELS;
        return (n > limit) ? limit : n;
    endfunction

    function automatic logic [MASK_W-1:0] low_bits(input int unsigned n);
        if (n >= MASK_W) begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    task automatic clear_maps();
        for (int r = 0; r < MAX_TILE_ROWS; r++) begin
            recent_map[r] = '0;
            stroke_map[r] = '0;
        end
    endtask

    task automatic apply_mark(input t_in_beat b);
        int unsigned cols;
        int unsigned rows;
        int unsigned sx;
        int unsigned sy;
        int unsigned x0;
        int unsigned y0;
        int unsigned x1;
        int unsigned y1;
        logic [MASK_W-1:0] span_mask;
        cols = tiles_spanned(canvas_width, MAX_TILE_COLS);
        rows = tiles_spanned(canvas_height, MAX_TILE_ROWS);
        // A negative origin is pulled to zero while the size stays as given.
        sx = b.rect_x[15] ? 0 : int'(b.rect_x[14:0]);
        sy = b.rect_y[15] ? 0 : int'(b.rect_y[14:0]);
        x0 = sx / TILE_PIXELS;
        y0 = sy / TILE_PIXELS;
        x1 = (sx + b.rect_w + TILE_PIXELS - 1) / TILE_PIXELS;
        y1 = (sy + b.rect_h + TILE_PIXELS - 1) / TILE_PIXELS;
        if (x1 > cols) x1 = cols;
        if (y1 > rows) y1 = rows;
        if (x0 >= x1 || y0 >= y1) begin
            return;
        end
        span_mask = low_bits(x1) & ~low_bits(x0);
        for (int unsigned r = y0; r < y1; r++) begin
            recent_map[r] = recent_map[r] | span_mask;
            stroke_map[r] = stroke_map[r] | span_mask;
        end
    endtask

    task automatic scan_map(input logic from_stroke);
        int unsigned rows;
        int last_dirty;
        logic [MASK_W-1:0] word;
        t_out_beat beat;
        rows = tiles_spanned(canvas_height, MAX_TILE_ROWS);
        last_dirty = -1;
        for (int r = 0; r < int'(rows); r++) begin
            word = from_stroke ? stroke_map[r] : recent_map[r];
            if (word != '0) last_dirty = r;
        end
        if (last_dirty < 0) begin
            beat.from_stroke_map = from_stroke;
            beat.tile_row        = '0;
            beat.column_mask     = '0;
            beat.last_row        = 1'b1;
            expected_rows.push_back(beat);
        end else begin
            for (int r = 0; r <= last_dirty; r++) begin
                word = from_stroke ? stroke_map[r] : recent_map[r];
                if (word != '0) begin
                    beat.from_stroke_map = from_stroke;
                    beat.tile_row        = OUT_ROW_W'(r);
                    beat.column_mask     = word;
                    beat.last_row        = (r == last_dirty);
                    expected_rows.push_back(beat);
                end
            end
        end
        for (int r = 0; r < MAX_TILE_ROWS; r++) begin
            if (from_stroke) begin
                stroke_map[r] = '0;
            end else begin
                recent_map[r] = '0;
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CANVAS_W-1:0] value);
        case (index)
            CFG_CANVAS_WIDTH: begin
                canvas_width = value;
                clear_maps();
            end
            CFG_CANVAS_HEIGHT: begin
                canvas_height = value;
                clear_maps();
            end
            default: ;
        endcase
    endtask

    task automatic check_row(input t_out_beat got);
        t_out_beat want;
        bit bad;
        if (expected_rows.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected row beat: stroke=%0d row=%0d mask=%h last=%0d",
                     $time, got.from_stroke_map, got.tile_row, got.column_mask,
                     got.last_row);
            return;
        end
        want = expected_rows.pop_front();
        bad = (got.from_stroke_map !== want.from_stroke_map)
            || (got.tile_row !== want.tile_row)
            || (got.column_mask !== want.column_mask)
            || (got.last_row !== want.last_row);
        if (bad) begin
            o_fail_count++;
            $display("%0t: row beat mismatch: expected stroke=%0d row=%0d mask=%h last=%0d",
                     $time, want.from_stroke_map, want.tile_row, want.column_mask,
                     want.last_row);
            $display("%0t:                    actual stroke=%0d row=%0d mask=%h last=%0d",
                     $time, got.from_stroke_map, got.tile_row, got.column_mask,
                     got.last_row);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            canvas_width  = CANVAS_RESET;
            canvas_height = CANVAS_RESET;
            clear_maps();
            expected_rows.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_row(i_out_beat);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_beat.command)
                    CMD_MARK:  apply_mark(i_in_beat);
                    CMD_TICK:  scan_map(1'b0);
                    CMD_FLUSH: scan_map(1'b1);
                    CMD_ABORT: clear_maps();
                    default: ;
                endcase
            end
        end
        o_pending = expected_rows.size();
    end

endmodule

// ----- tb/tb_dirty_tile_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile tracker testbench
// Drives directed and random marks, ticks, flushes and aborts over several
// canvas sizes, with random gaps on both channels and one long output stall.
// A checker beside the tracker predicts and compares every row beat.
// ----------------------------------------------------------------------------
module tb_dirty_tile_tracker_unit;
    import dtt_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 54;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 10000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_in_beat             i_data      = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_out_beat            o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CANVAS_W-1:0]  i_cfg_data  = '0;

    int rows_pending;
    int mismatch_count;
    int cycle_count = 0;
    bit no_idle     = 1'b0;
    bit hold_req    = 1'b0;
    int cur_w       = 4096;
    int cur_h       = 4096;

    dirty_tile_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    dirty_tile_checker rows_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_beat    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_beat   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (mismatch_count),
        .o_pending    (rows_pending)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_dirty_tile_tracker_unit: FAIL");
            $finish;
        end
    end

    function automatic int idle_gap();
        int pick;
        if (no_idle) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end
        if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] random_coord(input int span);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            v = int'($urandom_range(0, span + 63)) - 32;
        end else if (pick < 90) begin
            v = -int'($urandom_range(1, 300));
        end else begin
            v = int'($urandom());
        end
        return v[15:0];
    endfunction

    function automatic logic [14:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 15'($urandom_range(0, 200));
        end
        if (pick < 90) begin
            return 15'($urandom_range(0, 4200));
        end
        return 15'($urandom());
    endfunction

    function automatic t_in_beat random_request(input bit tick_heavy);
        t_in_beat b;
        int pick;
        pick     = $urandom_range(0, 99);
        b.rect_x = random_coord((cur_w == 0) ? 64 : cur_w);
        b.rect_y = random_coord((cur_h == 0) ? 64 : cur_h);
        b.rect_w = random_size();
        b.rect_h = random_size();
        if (tick_heavy) begin
            b.command = (pick < 45) ? CMD_MARK : (pick < 95) ? CMD_TICK : CMD_FLUSH;
        end else begin
            b.command = (pick < 62) ? CMD_MARK : (pick < 78) ? CMD_TICK :
                        (pick < 96) ? CMD_FLUSH : CMD_ABORT;
        end
        return b;
    endfunction

    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] x, input logic [15:0] y,
                            input logic [14:0] w, input logic [14:0] h);
        t_in_beat b;
        b.command = cmd;
        b.rect_x  = x;
        b.rect_y  = y;
        b.rect_w  = w;
        b.rect_h  = h;
        send_beat(b);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rows_pending != 0);
    endtask

    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CANVAS_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == CFG_CANVAS_WIDTH) cur_w = int'(value);
        if (index == CFG_CANVAS_HEIGHT) cur_h = int'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic cfg_idle();
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : row_sink
        int burst;
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= 1'b1;
                burst = $urandom_range(1, 24);
                repeat (burst) @(posedge i_clk);
                gap = idle_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : request_source
        int w;
        int h;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests on the reset canvas of 64 by 64 tiles.
        send_cmd(CMD_TICK,  16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_FLUSH, 16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'd1, 15'd1);
        send_cmd(CMD_MARK,  16'h8000, 16'h8000, 15'd100, 15'd100);
        send_cmd(CMD_MARK,  16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_MARK,  16'd4095, 16'd4032, 15'd1, 15'd1);
        send_cmd(CMD_TICK,  16'h7FFF, 16'h8000, 15'h7FFF, 15'd0);
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_TICK,  16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_FLUSH, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_MARK,  16'hFFFF, 16'hFFFF, 15'd0, 15'd0);
        send_cmd(CMD_MARK,  16'hFFC0, 16'd130, 15'd64, 15'd1);
        send_cmd(CMD_MARK,  16'd63, 16'd63, 15'd2, 15'd2);
        send_cmd(CMD_MARK,  16'd64, 16'd64, 15'd64, 15'd64);
        send_cmd(CMD_FLUSH, 16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_MARK,  16'd1000, 16'd2000, 15'd500, 15'd300);
        send_cmd(CMD_ABORT, 16'h7FFF, 16'h8000, 15'h7FFF, 15'h5555);
        send_cmd(CMD_TICK,  16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_FLUSH, 16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'd4096, 15'd4096);
        send_cmd(CMD_MARK,  16'h8000, 16'd0, 15'h7FFF, 15'd1);
        send_cmd(CMD_TICK,  16'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_FLUSH, 16'd0, 16'd0, 15'd0, 15'd0);

        // Writes to unused indexes must leave the maps alone.
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'd64, 15'd64);
        quiesce();
        write_reg(CFG_SPARE_LO, 13'h1FFF);
        write_reg(CFG_SPARE_HI, 13'h0000);
        cfg_idle();
        send_cmd(CMD_FLUSH, 16'd0, 16'd0, 15'd0, 15'd0);

        // A zero-sized canvas has no tiles to mark.
        quiesce();
        write_reg(CFG_CANVAS_WIDTH, 13'd0);
        cfg_idle();
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_TICK,  16'd0, 16'd0, 15'd0, 15'd0);
        quiesce();
        write_reg(CFG_CANVAS_WIDTH, 13'd4096);
        write_reg(CFG_CANVAS_HEIGHT, 13'd0);
        cfg_idle();
        send_cmd(CMD_MARK,  16'd0, 16'd0, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_FLUSH, 16'd0, 16'd0, 15'd0, 15'd0);

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            case (p)
                0: begin w = 4096; h = 4096; end
                1: begin w = 1;    h = 1;    end
                2: begin w = 4096; h = 4096; end
                3: begin w = 8191; h = 64;   end
                4: begin w = 64;   h = 8191; end
                5: begin w = 130;  h = 200;  end
                default: begin
                    w = $urandom_range(1, 4096);
                    h = $urandom_range(1, 4096);
                end
            endcase
            write_reg(CFG_CANVAS_WIDTH, w[CANVAS_W-1:0]);
            write_reg(CFG_CANVAS_HEIGHT, h[CANVAS_W-1:0]);
            cfg_idle();
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 10) hold_req = 1'b1;
                send_beat(random_request(p == 2 && n >= 10 && n < 40));
                if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
            end
        end
        no_idle = 1'b0;

        quiesce();
        if (mismatch_count == 0) begin
            $display("tb_dirty_tile_tracker_unit: PASS");
        end else begin
            $display("tb_dirty_tile_tracker_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/dtt_pkg.sv
hdl/dtt_ram.sv
hdl/dtt_quant.sv
hdl/dirty_tile_tracker_unit.sv
tb/dirty_tile_checker.sv
tb/tb_dirty_tile_tracker_unit.sv
